// File: hdl/baro_pkg.sv
// shared widths, constants, register indexes and stage transaction types
// for the barometer compensation core; no dependencies
package baro_pkg;

  // field widths
  localparam int RAW_W   = 24;
  localparam int CAL_W   = 16;
  localparam int TEMP_W  = 19;
  localparam int PRES_W  = 32;
  localparam int CFG_A_W = 3;

  // datapath widths
  localparam int TM_W    = 17;  // |dT|*temp_sens >> 23
  localparam int SQ_W    = 34;  // square of a temperature delta
  localparam int OFF2_W  = 39;
  localparam int SENS2_W = 38;
  localparam int OFF_W   = 42;
  localparam int SENS_W  = 40;
  localparam int SMAG_W  = 39;
  localparam int SLO_W   = 20;  // low slice of |SENS| for the split multiply
  localparam int FULL_W  = 63;
  localparam int P_W     = 44;

  // pipeline depth from accepted transaction to result strobe
  localparam int LATENCY = 11;

  // temperature constants
  localparam logic signed [TEMP_W-1:0] TEMP_BASE = 19'sd2000;
  localparam logic [TM_W-1:0]          COLD_MAG  = 17'd3500;  // 20.00 to -15.00 degrees

  // configuration register indexes
  localparam logic [CFG_A_W-1:0] REG_SENS_T1   = 3'd0;
  localparam logic [CFG_A_W-1:0] REG_OFF_T1    = 3'd1;
  localparam logic [CFG_A_W-1:0] REG_TCS       = 3'd2;
  localparam logic [CFG_A_W-1:0] REG_TCO       = 3'd3;
  localparam logic [CFG_A_W-1:0] REG_T_REF     = 3'd4;
  localparam logic [CFG_A_W-1:0] REG_TEMP_SENS = 3'd5;

  // reset values of the calibration words
  localparam logic [CAL_W-1:0] RST_SENS_T1   = 16'd40127;
  localparam logic [CAL_W-1:0] RST_OFF_T1    = 16'd36924;
  localparam logic [CAL_W-1:0] RST_TCS       = 16'd23317;
  localparam logic [CAL_W-1:0] RST_TCO       = 16'd23282;
  localparam logic [CAL_W-1:0] RST_T_REF     = 16'd33464;
  localparam logic [CAL_W-1:0] RST_TEMP_SENS = 16'd28312;

  // compensated terms handed to the pressure path
  typedef struct packed {
    logic                     vld;
    logic [RAW_W-1:0]         d1;
    logic signed [TEMP_W-1:0] temp;
    logic signed [OFF_W-1:0]  off;
    logic signed [SENS_W-1:0] sens;
  } pres_req_t;

  // finished result
  typedef struct packed {
    logic                     vld;
    logic signed [TEMP_W-1:0] temp;
    logic signed [PRES_W-1:0] pressure;
  } pres_rsp_t;

endpackage

// File: hdl/baro_pres_path.sv
// pressure back end: |SENS| split multiply by D1, offset subtract, shift
// depends on baro_pkg
module baro_pres_path (
  input  logic                clk,
  input  logic                rst_n,
  input  baro_pkg::pres_req_t req,
  output baro_pkg::pres_rsp_t rsp
);

  // valid bits of stages p1..p4, result register separate
  logic [3:0] vld_r;
  logic       out_vld_r;

  // p1: sign and magnitude of SENS
  logic                                       p1_sneg_r, p1_sneg_nxt;
  logic [baro_pkg::SMAG_W-1:0]                p1_smag_r, p1_smag_nxt;
  logic [baro_pkg::RAW_W-1:0]                 p1_d1_r;
  logic signed [baro_pkg::OFF_W-1:0]          p1_off_r;
  logic signed [baro_pkg::TEMP_W-1:0]         p1_temp_r;
  logic signed [baro_pkg::SENS_W-1:0]         sens_abs;

  // p2: partial products
  logic [baro_pkg::RAW_W+baro_pkg::SLO_W-1:0]                  p2_lo_r, p2_lo_nxt;
  logic [baro_pkg::RAW_W+baro_pkg::SMAG_W-baro_pkg::SLO_W-1:0] p2_hi_r, p2_hi_nxt;
  logic                                       p2_sneg_r;
  logic signed [baro_pkg::OFF_W-1:0]          p2_off_r;
  logic signed [baro_pkg::TEMP_W-1:0]         p2_temp_r;

  // p3: full product
  logic [baro_pkg::FULL_W-1:0]                p3_full_r, p3_full_nxt;
  logic                                       p3_sneg_r;
  logic signed [baro_pkg::OFF_W-1:0]          p3_off_r;
  logic signed [baro_pkg::TEMP_W-1:0]         p3_temp_r;

  // p4: signed pressure before the final shift
  logic signed [baro_pkg::P_W-1:0]            p4_p_r, p4_p_nxt;
  logic signed [baro_pkg::TEMP_W-1:0]         p4_temp_r;
  logic signed [baro_pkg::P_W-1:0]            q_s, off_s;

  // result register
  logic signed [baro_pkg::PRES_W-1:0]         out_pres_r, out_pres_nxt;
  logic signed [baro_pkg::TEMP_W-1:0]         out_temp_r;
  logic signed [baro_pkg::P_W-1:0]            p_adj;

  // valid chain
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r     <= '0;
      out_vld_r <= 1'b0;
    end else begin
      vld_r     <= {vld_r[2:0], req.vld};
      out_vld_r <= vld_r[3];
    end
  end

  // p1 next: absolute value of SENS
  always_comb begin
    p1_sneg_nxt = req.sens[baro_pkg::SENS_W-1];
    sens_abs    = p1_sneg_nxt ? -req.sens : req.sens;
    p1_smag_nxt = sens_abs[baro_pkg::SMAG_W-1:0];
  end

  // p2 next: D1 times low and high slices of |SENS|
  always_comb begin
    p2_lo_nxt = (baro_pkg::RAW_W+baro_pkg::SLO_W)'(p1_d1_r)
              * (baro_pkg::RAW_W+baro_pkg::SLO_W)'(p1_smag_r[baro_pkg::SLO_W-1:0]);
    p2_hi_nxt = (baro_pkg::RAW_W+baro_pkg::SMAG_W-baro_pkg::SLO_W)'(p1_d1_r)
              * (baro_pkg::RAW_W+baro_pkg::SMAG_W-baro_pkg::SLO_W)'(
                  p1_smag_r[baro_pkg::SMAG_W-1:baro_pkg::SLO_W]);
  end

  // p3 next: recombine the partial products
  always_comb begin
    p3_full_nxt = {p2_hi_r, {baro_pkg::SLO_W{1'b0}}} + baro_pkg::FULL_W'(p2_lo_r);
  end

  // p4 next: signed (D1*SENS >> 21) minus OFF
  always_comb begin
    q_s      = $signed({2'b00, p3_full_r[baro_pkg::FULL_W-1:21]});
    off_s    = {{(baro_pkg::P_W-baro_pkg::OFF_W){p3_off_r[baro_pkg::OFF_W-1]}}, p3_off_r};
    p4_p_nxt = p3_sneg_r ? (-q_s - off_s) : (q_s - off_s);
  end

  // result next: divide by 2^15 rounding toward zero, sign-extend to 32 bits
  always_comb begin
    p_adj        = p4_p_r + (p4_p_r[baro_pkg::P_W-1] ? 44'sd32767 : 44'sd0);
    out_pres_nxt = {{3{p_adj[baro_pkg::P_W-1]}}, p_adj[baro_pkg::P_W-1:15]};
  end

  // payload registers
  always_ff @(posedge clk) begin
    p1_sneg_r  <= p1_sneg_nxt;
    p1_smag_r  <= p1_smag_nxt;
    p1_d1_r    <= req.d1;
    p1_off_r   <= req.off;
    p1_temp_r  <= req.temp;
    p2_lo_r    <= p2_lo_nxt;
    p2_hi_r    <= p2_hi_nxt;
    p2_sneg_r  <= p1_sneg_r;
    p2_off_r   <= p1_off_r;
    p2_temp_r  <= p1_temp_r;
    p3_full_r  <= p3_full_nxt;
    p3_sneg_r  <= p2_sneg_r;
    p3_off_r   <= p2_off_r;
    p3_temp_r  <= p2_temp_r;
    p4_p_r     <= p4_p_nxt;
    p4_temp_r  <= p3_temp_r;
    out_pres_r <= out_pres_nxt;
    out_temp_r <= p4_temp_r;
  end

  assign rsp.vld      = out_vld_r;
  assign rsp.temp     = out_temp_r;
  assign rsp.pressure = out_pres_r;

endmodule

// File: hdl/barometer_compensation_core.sv
// top level of the barometer compensation core: calibration registers,
// temperature, OFF and SENS pipeline; depends on baro_pkg and baro_pres_path
//
//  channel | ports                                    | transaction
//  --------+------------------------------------------+-----------------------------
//  input   | start, busy, in_raw_pressure/temperature | start high and busy low
//  result  | out_valid, out_temperature, out_pressure | out_valid high for one cycle
//  config  | cfg_we, cfg_addr, cfg_wdata              | cfg_we high, no wait
//
//  a transaction can be taken every cycle; busy is always low
//  its result passes six stages here and five in the pressure path, a depth
//  set by the split D1*SENS multiply and the square terms
//  synchronous reset clears valid bits and loads the factory calibration words
//  the receiver cannot stall, so nothing in the pipeline ever waits
module barometer_compensation_core (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  logic [baro_pkg::RAW_W-1:0]         in_raw_pressure,
  input  logic [baro_pkg::RAW_W-1:0]         in_raw_temperature,
  output logic                               out_valid,
  output logic signed [baro_pkg::TEMP_W-1:0] out_temperature,
  output logic signed [baro_pkg::PRES_W-1:0] out_pressure,
  input  logic                               cfg_we,
  input  logic [baro_pkg::CFG_A_W-1:0]       cfg_addr,
  input  logic [baro_pkg::CAL_W-1:0]         cfg_wdata
);

  // calibration registers
  logic [baro_pkg::CAL_W-1:0] sens_t1_r, off_t1_r, tcs_r, tco_r, t_ref_r, temp_sens_r;

  // valid bits of stages s1..s6
  logic [5:0] vld_r;
  logic       accept;

  // s1: |dT| and sign
  logic [baro_pkg::RAW_W-1:0] s1_dt_r, s1_dt_nxt, s1_d1_r, tref;
  logic                       s1_neg_r, s1_neg_nxt;

  // s2: products of |dT|
  logic [39:0]                s2_pt_r, s2_pt_nxt, s2_po_r, s2_po_nxt, s2_ps_r, s2_ps_nxt;
  logic [47:0]                s2_pq_r, s2_pq_nxt;
  logic                       s2_neg_r;
  logic [baro_pkg::RAW_W-1:0] s2_d1_r;

  // s3: first-order terms
  logic signed [baro_pkg::TEMP_W-1:0] s3_temp_r, s3_temp_nxt;
  logic signed [baro_pkg::OFF_W-1:0]  s3_off_r, s3_off_nxt;
  logic signed [baro_pkg::SENS_W-1:0] s3_sens_r, s3_sens_nxt;
  logic [baro_pkg::TM_W-1:0]          s3_t2_r, s3_t2_nxt, s3_dm_r, s3_dm_nxt;
  logic [baro_pkg::TM_W-1:0]          s3_cm_r, s3_cm_nxt;
  logic [baro_pkg::RAW_W-1:0]         s3_d1_r;
  logic [baro_pkg::TM_W-1:0]          tm;
  logic                               cold, vcold;

  // s4: squares of the temperature deltas
  logic [baro_pkg::SQ_W-1:0]          s4_sq_r, s4_sq_nxt, s4_cq_r, s4_cq_nxt;
  logic signed [baro_pkg::TEMP_W-1:0] s4_temp_r;
  logic signed [baro_pkg::OFF_W-1:0]  s4_off_r;
  logic signed [baro_pkg::SENS_W-1:0] s4_sens_r;
  logic [baro_pkg::TM_W-1:0]          s4_t2_r;
  logic [baro_pkg::RAW_W-1:0]         s4_d1_r;

  // s5: second-order corrections, final temperature
  logic [baro_pkg::OFF2_W-1:0]        s5_off2_r, s5_off2_nxt;
  logic [baro_pkg::SENS2_W-1:0]       s5_sens2_r, s5_sens2_nxt;
  logic signed [baro_pkg::TEMP_W-1:0] s5_temp_r, s5_temp_nxt;
  logic signed [baro_pkg::OFF_W-1:0]  s5_off_r;
  logic signed [baro_pkg::SENS_W-1:0] s5_sens_r;
  logic [baro_pkg::RAW_W-1:0]         s5_d1_r;
  logic [39:0]                        sq61;

  // s6: corrected OFF and SENS
  logic signed [baro_pkg::OFF_W-1:0]  s6_off_r, s6_off_nxt;
  logic signed [baro_pkg::SENS_W-1:0] s6_sens_r, s6_sens_nxt;
  logic signed [baro_pkg::TEMP_W-1:0] s6_temp_r;
  logic [baro_pkg::RAW_W-1:0]         s6_d1_r;

  baro_pkg::pres_req_t req;
  baro_pkg::pres_rsp_t rsp;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  // calibration register writes, unknown indexes ignored
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sens_t1_r   <= baro_pkg::RST_SENS_T1;
      off_t1_r    <= baro_pkg::RST_OFF_T1;
      tcs_r       <= baro_pkg::RST_TCS;
      tco_r       <= baro_pkg::RST_TCO;
      t_ref_r     <= baro_pkg::RST_T_REF;
      temp_sens_r <= baro_pkg::RST_TEMP_SENS;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        baro_pkg::REG_SENS_T1:   sens_t1_r   <= cfg_wdata;
        baro_pkg::REG_OFF_T1:    off_t1_r    <= cfg_wdata;
        baro_pkg::REG_TCS:       tcs_r       <= cfg_wdata;
        baro_pkg::REG_TCO:       tco_r       <= cfg_wdata;
        baro_pkg::REG_T_REF:     t_ref_r     <= cfg_wdata;
        baro_pkg::REG_TEMP_SENS: temp_sens_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // valid chain
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[4:0], accept};
    end
  end

  // s1 next: dT as magnitude and sign
  always_comb begin
    tref       = {t_ref_r, 8'h00};
    s1_neg_nxt = in_raw_temperature < tref;
    s1_dt_nxt  = s1_neg_nxt ? (tref - in_raw_temperature) : (in_raw_temperature - tref);
  end

  // s2 next: one multiplier per coefficient, plus dT squared
  always_comb begin
    s2_pt_nxt = 40'(s1_dt_r) * 40'(temp_sens_r);
    s2_po_nxt = 40'(s1_dt_r) * 40'(tco_r);
    s2_ps_nxt = 40'(s1_dt_r) * 40'(tcs_r);
    s2_pq_nxt = 48'(s1_dt_r) * 48'(s1_dt_r);
  end

  // s3 next: truncated magnitudes with sign, cold-range decisions
  always_comb begin
    tm          = s2_pt_r[39:23];
    cold        = s2_neg_r && (tm != '0);
    vcold       = s2_neg_r && (tm > baro_pkg::COLD_MAG);
    s3_temp_nxt = s2_neg_r ? (baro_pkg::TEMP_BASE - $signed({2'b00, tm}))
                           : (baro_pkg::TEMP_BASE + $signed({2'b00, tm}));
    s3_off_nxt  = s2_neg_r ? ($signed({9'd0, off_t1_r, 17'd0}) - $signed({8'd0, s2_po_r[39:6]}))
                           : ($signed({9'd0, off_t1_r, 17'd0}) + $signed({8'd0, s2_po_r[39:6]}));
    s3_sens_nxt = s2_neg_r ? ($signed({8'd0, sens_t1_r, 16'd0}) - $signed({7'd0, s2_ps_r[39:7]}))
                           : ($signed({8'd0, sens_t1_r, 16'd0}) + $signed({7'd0, s2_ps_r[39:7]}));
    s3_t2_nxt   = cold ? s2_pq_r[47:31] : '0;
    // |TEMP-2000| and |TEMP+1500|, zero outside their ranges
    s3_dm_nxt   = cold ? tm : '0;
    s3_cm_nxt   = vcold ? (tm - baro_pkg::COLD_MAG) : '0;
  end

  // s4 next: squares
  always_comb begin
    s4_sq_nxt = baro_pkg::SQ_W'(s3_dm_r) * baro_pkg::SQ_W'(s3_dm_r);
    s4_cq_nxt = baro_pkg::SQ_W'(s3_cm_r) * baro_pkg::SQ_W'(s3_cm_r);
  end

  // s5 next: OFF2, SENS2 and temperature minus T2
  always_comb begin
    sq61         = 40'(s4_sq_r) * 40'd61;
    s5_off2_nxt  = baro_pkg::OFF2_W'(sq61 >> 4)
                 + baro_pkg::OFF2_W'(baro_pkg::OFF2_W'(s4_cq_r) * baro_pkg::OFF2_W'(15));
    s5_sens2_nxt = baro_pkg::SENS2_W'({s4_sq_r, 1'b0})
                 + baro_pkg::SENS2_W'({s4_cq_r, 3'b000});
    s5_temp_nxt  = s4_temp_r - $signed({2'b00, s4_t2_r});
  end

  // s6 next: apply the second-order corrections
  always_comb begin
    s6_off_nxt  = s5_off_r - $signed({3'b000, s5_off2_r});
    s6_sens_nxt = s5_sens_r - $signed({2'b00, s5_sens2_r});
  end

  // payload registers
  always_ff @(posedge clk) begin
    s1_dt_r    <= s1_dt_nxt;
    s1_neg_r   <= s1_neg_nxt;
    s1_d1_r    <= in_raw_pressure;
    s2_pt_r    <= s2_pt_nxt;
    s2_po_r    <= s2_po_nxt;
    s2_ps_r    <= s2_ps_nxt;
    s2_pq_r    <= s2_pq_nxt;
    s2_neg_r   <= s1_neg_r;
    s2_d1_r    <= s1_d1_r;
    s3_temp_r  <= s3_temp_nxt;
    s3_off_r   <= s3_off_nxt;
    s3_sens_r  <= s3_sens_nxt;
    s3_t2_r    <= s3_t2_nxt;
    s3_dm_r    <= s3_dm_nxt;
    s3_cm_r    <= s3_cm_nxt;
    s3_d1_r    <= s2_d1_r;
    s4_sq_r    <= s4_sq_nxt;
    s4_cq_r    <= s4_cq_nxt;
    s4_temp_r  <= s3_temp_r;
    s4_off_r   <= s3_off_r;
    s4_sens_r  <= s3_sens_r;
    s4_t2_r    <= s3_t2_r;
    s4_d1_r    <= s3_d1_r;
    s5_off2_r  <= s5_off2_nxt;
    s5_sens2_r <= s5_sens2_nxt;
    s5_temp_r  <= s5_temp_nxt;
    s5_off_r   <= s4_off_r;
    s5_sens_r  <= s4_sens_r;
    s5_d1_r    <= s4_d1_r;
    s6_off_r   <= s6_off_nxt;
    s6_sens_r  <= s6_sens_nxt;
    s6_temp_r  <= s5_temp_r;
    s6_d1_r    <= s5_d1_r;
  end

  // hand over to the pressure path
  assign req.vld  = vld_r[5];
  assign req.d1   = s6_d1_r;
  assign req.temp = s6_temp_r;
  assign req.off  = s6_off_r;
  assign req.sens = s6_sens_r;

  baro_pres_path u_pres (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (req),
    .rsp   (rsp)
  );

  assign out_valid       = rsp.vld;
  assign out_temperature = rsp.temp;
  assign out_pressure    = rsp.pressure;

endmodule

// File: hdl/baro_comp_checker.sv
// port-level checker for the barometer compensation core, bound to the top
// depends on baro_pkg and barometer_compensation_core
module baro_comp_checker (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic out_valid
);

  // every accepted transaction gives a result after the fixed latency
  assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##(baro_pkg::LATENCY) out_valid)
    else $error("accepted transaction produced no result");

  // no result without a transaction accepted at the fixed latency before
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, baro_pkg::LATENCY))
    else $error("result strobe without a matching transaction");

  // reset empties the pipeline
  assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result strobe straight after reset");

endmodule

bind barometer_compensation_core baro_comp_checker u_chk (.*);

// File: tb/barometer_compensation_core_tb.sv
// testbench for the barometer compensation core: drives raw conversion pairs and
// calibration writes, predicts each compensated reading and checks it field by field
// depends on baro_pkg and barometer_compensation_core
module barometer_compensation_core_tb;
  import baro_pkg::*;

  typedef longint unsigned u64_t;

  // one compensated reading as the result channel carries it
  typedef struct {
    logic signed [TEMP_W-1:0] temp;
    logic signed [PRES_W-1:0] pressure;
  } reading_t;

  // register indexes the core does not decode
  localparam logic [CFG_A_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [CFG_A_W-1:0] REG_SPARE_HI = 3'd7;

  localparam int STALL_LIMIT = 1000;
  localparam int ITEMS_PER_SETTING = 330;

  logic                     clk = 1'b0;
  logic                     rst_n;
  logic                     start;
  logic                     busy;
  logic [RAW_W-1:0]         in_raw_pressure;
  logic [RAW_W-1:0]         in_raw_temperature;
  logic                     out_valid;
  logic signed [TEMP_W-1:0] out_temperature;
  logic signed [PRES_W-1:0] out_pressure;
  logic                     cfg_we;
  logic [CFG_A_W-1:0]       cfg_addr;
  logic [CAL_W-1:0]         cfg_wdata;

  // calibration words as the core should hold them
  logic [CAL_W-1:0] cal_sens_t1;
  logic [CAL_W-1:0] cal_off_t1;
  logic [CAL_W-1:0] cal_tcs;
  logic [CAL_W-1:0] cal_tco;
  logic [CAL_W-1:0] cal_t_ref;
  logic [CAL_W-1:0] cal_temp_sens;

  reading_t expected_readings[$];
  int       mismatches = 0;
  int       stalled_cycles = 0;
  int       idle_pct = 0;

  barometer_compensation_core DUT (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_raw_pressure    (in_raw_pressure),
    .in_raw_temperature (in_raw_temperature),
    .out_valid          (out_valid),
    .out_temperature    (out_temperature),
    .out_pressure       (out_pressure),
    .cfg_we             (cfg_we),
    .cfg_addr           (cfg_addr),
    .cfg_wdata          (cfg_wdata)
  );

  // clock, period 20
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // signed value from a magnitude and a sign
  function automatic longint with_sign(input u64_t mag, input bit neg);
    return neg ? -longint'(mag) : longint'(mag);
  endfunction

  // first and second order compensation of one conversion pair
  function automatic reading_t compensate(input logic [RAW_W-1:0] d1,
                                          input logic [RAW_W-1:0] d2);
    u64_t     d1w, d2w, tref, dt, word, smag, pmag;
    longint   temp, off, sens, t2, dlt, sq, off2, sens2, cq, p;
    bit       neg, sneg, pneg;
    reading_t r;
    d1w  = d1;
    d2w  = d2;
    tref = cal_t_ref;
    tref = tref << 8;
    neg  = d2w < tref;
    dt   = neg ? tref - d2w : d2w - tref;

    // first order terms, each shifted product truncated before the sign
    temp = 2000 + with_sign((dt * cal_temp_sens) >> 23, neg);
    word = cal_off_t1;
    off  = longint'(word << 17) + with_sign((dt * cal_tco) >> 6, neg);
    word = cal_sens_t1;
    sens = longint'(word << 16) + with_sign((dt * cal_tcs) >> 7, neg);

    // second order correction below 20.00 degrees, extra terms below -15.00
    if (temp < 2000) begin
      t2    = longint'((dt * dt) >> 31);
      dlt   = temp - 2000;
      sq    = dlt * dlt;
      off2  = (61 * sq) >>> 4;
      sens2 = 2 * sq;
      if (temp < -1500) begin
        cq    = (temp + 1500) * (temp + 1500);
        off2  = off2 + 15 * cq;
        sens2 = sens2 + 8 * cq;
      end
      temp = temp - t2;
      off  = off - off2;
      sens = sens - sens2;
    end

    // pressure, both divisions truncating toward zero
    sneg = sens < 0;
    smag = sneg ? u64_t'(-sens) : u64_t'(sens);
    p    = with_sign((d1w * smag) >> 21, sneg) - off;
    pneg = p < 0;
    pmag = pneg ? u64_t'(-p) : u64_t'(p);
    p    = with_sign(pmag >> 15, pneg);

    r.temp     = temp[TEMP_W-1:0];
    r.pressure = p[PRES_W-1:0];
    return r;
  endfunction

  // one line for each of the first 100 mismatches, every mismatch counted
  task automatic report_mismatch(input string what);
    mismatches++;
    if (mismatches <= 100)
      $display("mismatch at %0t: %s", $time, what);
  endtask

  // calibration write, core idle
  task automatic write_cal(input logic [CFG_A_W-1:0] idx, input logic [CAL_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_SENS_T1:   cal_sens_t1   = val;
      REG_OFF_T1:    cal_off_t1    = val;
      REG_TCS:       cal_tcs       = val;
      REG_TCO:       cal_tco       = val;
      REG_T_REF:     cal_t_ref     = val;
      REG_TEMP_SENS: cal_temp_sens = val;
      default: ;
    endcase
    @(posedge clk);
  endtask

  // hold the input off until every reading is back and the pipeline is empty
  task automatic settle();
    start <= 1'b0;
    while (expected_readings.size() != 0) @(posedge clk);
    repeat (LATENCY) @(posedge clk);
  endtask

  // one input transaction, each cycle before it idle with the set percentage
  task automatic send_pair(input logic [RAW_W-1:0] d1, input logic [RAW_W-1:0] d2);
    while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start              <= 1'b1;
    in_raw_pressure    <= d1;
    in_raw_temperature <= d2;
    @(posedge clk);
    while (busy) @(posedge clk);
    expected_readings.push_back(compensate(d1, d2));
  endtask

  // factory words: field extremes, zero dT and a sweep into the very cold range
  task automatic test_factory_calibration();
    logic [RAW_W-1:0] tref;
    tref = {cal_t_ref, 8'h00};
    send_pair(24'h000000, 24'h000000);
    send_pair(24'hFFFFFF, 24'hFFFFFF);
    send_pair(24'h000000, 24'hFFFFFF);
    send_pair(24'hFFFFFF, 24'h000000);
    send_pair(24'h800000, tref);
    send_pair(24'h800000, tref - 24'd1);
    send_pair(24'h800000, tref + 24'd1);
    for (int k = 4; k <= 22; k += 3)
      send_pair(RAW_W'($urandom), tref - (24'd1 << k));
  endtask

  // all words at zero, then all at full scale; spare indexes must be ignored
  task automatic test_calibration_extremes();
    settle();
    for (int i = 0; i < 6; i++) write_cal(CFG_A_W'(i), 16'h0000);
    write_cal(REG_SPARE_LO, CAL_W'($urandom));
    write_cal(REG_SPARE_HI, CAL_W'($urandom));
    send_pair(24'hFFFFFF, 24'h000000);
    send_pair(24'hFFFFFF, 24'hFFFFFF);
    send_pair(24'h000000, 24'h123456);
    settle();
    for (int i = 0; i < 6; i++) write_cal(CFG_A_W'(i), 16'hFFFF);
    send_pair(24'hFFFFFF, 24'h000000);
    send_pair(24'hFFFFFF, 24'hFFFFFF);
    send_pair(24'hFFFFFF, 24'hFFFF00);
    send_pair(24'h000001, 24'h000000);
  endtask

  // random words and random conversion pairs, biased around the reference reading
  task automatic test_random_traffic(input int pct);
    logic [RAW_W-1:0] d1, d2;
    int               t, dist_mag;
    idle_pct = pct;
    for (int setting = 0; setting < 2; setting++) begin
      settle();
      for (int i = 0; i < 6; i++) begin
        case ($urandom_range(7))
          0:       write_cal(CFG_A_W'(i), 16'h0000);
          1:       write_cal(CFG_A_W'(i), 16'hFFFF);
          default: write_cal(CFG_A_W'(i), CAL_W'($urandom));
        endcase
      end
      if ($urandom_range(3) == 0)
        write_cal(CFG_A_W'($urandom_range(7, 6)), CAL_W'($urandom));
      for (int n = 0; n < ITEMS_PER_SETTING; n++) begin
        case ($urandom_range(15))
          0:       d1 = '0;
          1:       d1 = '1;
          default: d1 = RAW_W'($urandom);
        endcase
        case ($urandom_range(3))
          // near zero dT, either side
          2: begin
            dist_mag = $urandom_range(4095);
            t = $urandom_range(1) ? int'({cal_t_ref, 8'h00}) + dist_mag
                                  : int'({cal_t_ref, 8'h00}) - dist_mag;
          end
          // cold and very cold
          3: t = int'({cal_t_ref, 8'h00}) - int'($urandom_range(1 << 22));
          default: t = int'($urandom_range(24'hFFFFFF));
        endcase
        if (t < 0) t = 0;
        if (t > 24'hFFFFFF) t = 24'hFFFFFF;
        d2 = RAW_W'(t);
        send_pair(d1, d2);
        // one full drain in the middle of each setting
        if (n == ITEMS_PER_SETTING / 2) settle();
      end
    end
  endtask

  // result checker, oldest expectation first
  always @(posedge clk) begin : check_reading
    reading_t want;
    if (rst_n && out_valid) begin
      if (expected_readings.size() == 0) begin
        report_mismatch($sformatf("unexpected reading temperature %0d pressure %0d",
                                  out_temperature, out_pressure));
      end else begin
        want = expected_readings.pop_front();
        if (out_temperature !== want.temp)
          report_mismatch($sformatf("temperature %0d, expected %0d",
                                    out_temperature, want.temp));
        if (out_pressure !== want.pressure)
          report_mismatch($sformatf("pressure %0d, expected %0d",
                                    out_pressure, want.pressure));
      end
    end
  end

  // watchdog on cycles with no transaction of any kind
  always @(posedge clk) begin
    if ((start && !busy) || out_valid || cfg_we)
      stalled_cycles <= 0;
    else
      stalled_cycles <= stalled_cycles + 1;
    if (stalled_cycles >= STALL_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // test sequence
  initial begin
    rst_n              <= 1'b0;
    start              <= 1'b0;
    in_raw_pressure    <= '0;
    in_raw_temperature <= '0;
    cfg_we             <= 1'b0;
    cfg_addr           <= '0;
    cfg_wdata          <= '0;
    cal_sens_t1   = RST_SENS_T1;
    cal_off_t1    = RST_OFF_T1;
    cal_tcs       = RST_TCS;
    cal_tco       = RST_TCO;
    cal_t_ref     = RST_T_REF;
    cal_temp_sens = RST_TEMP_SENS;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_factory_calibration();
    test_calibration_extremes();
    test_random_traffic(38);
    test_random_traffic(51);
    test_random_traffic(0);
    settle();

    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// File: sim.f
hdl/baro_pkg.sv
hdl/baro_pres_path.sv
hdl/barometer_compensation_core.sv
hdl/baro_comp_checker.sv
tb/barometer_compensation_core_tb.sv
